// ----- hdl/assert_macros.svh -----
// Shared assertion macros for the resonator checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ----- hdl/tpr_pkg.sv -----
package tpr_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS_DEF   = 18;
  localparam int HEADROOM_BITS   = 8;
  localparam int NUM_COEFS       = 5;
  localparam int STEP_BITS       = 4;
  localparam int ADDR_BITS       = 5;
  localparam int DATA_BITS       = 32;

  typedef enum logic [2:0] {
    REG_FB1 = 3'd0,
    REG_FB2 = 3'd1,
    REG_FF0 = 3'd2,
    REG_FF1 = 3'd3,
    REG_FF2 = 3'd4
  } reg_idx_t;

  localparam int COEF_RESET [NUM_COEFS] = '{-26044, 2621, 31457, 0, -31457};

  typedef enum logic [2:0] {
    MUL_FB1,
    MUL_FB2,
    MUL_FF0,
    MUL_FF1,
    MUL_FF2
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_LOAD_P,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jmp_t;

  typedef struct packed {
    mul_sel_t             mul_sel;
    acc_op_t              acc_op;
    logic                 latch_w;
    logic                 emit;
    jmp_t                 jmp;
    logic                 jump;
    logic [STEP_BITS-1:0] target;
  } ctrl_word_t;

  localparam logic [STEP_BITS-1:0] STEP_IDLE = '0;

  function automatic ctrl_word_t ucode(input logic [STEP_BITS-1:0] step);
    ctrl_word_t w;
    w = '{MUL_FB1, ACC_HOLD, 1'b0, 1'b0, JMP_NEXT, 1'b0, STEP_IDLE};
    case (step)
      4'd0: w = '{MUL_FB1, ACC_LOAD_X, 1'b0, 1'b0, JMP_WAIT_IN, 1'b0, STEP_IDLE};
      4'd1: w = '{MUL_FB2, ACC_SUB, 1'b0, 1'b0, JMP_NEXT, 1'b0, STEP_IDLE};
      4'd2: w = '{MUL_FB2, ACC_SUB, 1'b0, 1'b0, JMP_NEXT, 1'b0, STEP_IDLE};
      4'd3: w = '{MUL_FF0, ACC_HOLD, 1'b1, 1'b0, JMP_NEXT, 1'b0, STEP_IDLE};
      4'd4: w = '{MUL_FF0, ACC_HOLD, 1'b0, 1'b0, JMP_NEXT, 1'b0, STEP_IDLE};
      4'd5: w = '{MUL_FF1, ACC_LOAD_P, 1'b0, 1'b0, JMP_NEXT, 1'b0, STEP_IDLE};
      4'd6: w = '{MUL_FF2, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, 1'b0, STEP_IDLE};
      4'd7: w = '{MUL_FF2, ACC_ADD, 1'b0, 1'b0, JMP_NEXT, 1'b0, STEP_IDLE};
      4'd8: w = '{MUL_FB1, ACC_HOLD, 1'b0, 1'b1, JMP_WAIT_OUT, 1'b1, STEP_IDLE};
      default: w = '{MUL_FB1, ACC_HOLD, 1'b0, 1'b0, JMP_NEXT, 1'b1, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/tpr_datapath.sv -----
module tpr_datapath #(
  parameter int SAMPLE_BITS = tpr_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = tpr_pkg::COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tpr_pkg::ctrl_word_t           ctrl,
  input  logic                          advance,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [COEF_BITS-1:0]   coef [tpr_pkg::NUM_COEFS],
  output logic signed [SAMPLE_BITS-1:0] sample_out_next
);
  import tpr_pkg::*;

  localparam int STATE_BITS = SAMPLE_BITS + HEADROOM_BITS;
  localparam int FRAC_BITS  = COEF_BITS - 2;
  localparam int PROD_BITS  = COEF_BITS + STATE_BITS;
  localparam int ACC_BITS   = PROD_BITS + 2;

  localparam logic signed [ACC_BITS:0] ROUND_HALF = (ACC_BITS + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_BITS:0] STATE_MAX =
    signed'({{(ACC_BITS + 2 - STATE_BITS){1'b0}}, {(STATE_BITS - 1){1'b1}}});
  localparam logic signed [ACC_BITS:0] STATE_MIN = ~STATE_MAX;
  localparam logic signed [ACC_BITS:0] SAMPLE_MAX =
    signed'({{(ACC_BITS + 2 - SAMPLE_BITS){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
  localparam logic signed [ACC_BITS:0] SAMPLE_MIN = ~SAMPLE_MAX;

  logic signed [COEF_BITS-1:0]  op_c;
  logic signed [STATE_BITS-1:0] op_s;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [ACC_BITS-1:0]   prod_ext;
  logic signed [ACC_BITS-1:0]   x_scaled;
  logic signed [ACC_BITS-1:0]   acc;
  logic signed [ACC_BITS:0]     acc_half;
  logic signed [ACC_BITS:0]     rnd;
  logic signed [STATE_BITS-1:0] w_sat;
  logic signed [STATE_BITS-1:0] w_new;
  logic signed [STATE_BITS-1:0] w1;
  logic signed [STATE_BITS-1:0] w2;

  always_comb begin
    case (ctrl.mul_sel)
      MUL_FB1: begin
        op_c = coef[REG_FB1];
        op_s = w1;
      end
      MUL_FB2: begin
        op_c = coef[REG_FB2];
        op_s = w2;
      end
      MUL_FF0: begin
        op_c = coef[REG_FF0];
        op_s = w_new;
      end
      MUL_FF1: begin
        op_c = coef[REG_FF1];
        op_s = w1;
      end
      MUL_FF2: begin
        op_c = coef[REG_FF2];
        op_s = w2;
      end
      default: begin
        op_c = '0;
        op_s = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_c * op_s;
  end

  assign prod_ext = {{2{prod[PROD_BITS-1]}}, prod};
  assign x_scaled = {{(ACC_BITS - SAMPLE_BITS){sample_in[SAMPLE_BITS-1]}}, sample_in}
                    <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (advance) begin
      case (ctrl.acc_op)
        ACC_LOAD_X: acc <= x_scaled;
        ACC_LOAD_P: acc <= prod_ext;
        ACC_ADD:    acc <= acc + prod_ext;
        ACC_SUB:    acc <= acc - prod_ext;
        default:    acc <= acc;
      endcase
    end
  end

  assign acc_half = {acc[ACC_BITS-1], acc} + ROUND_HALF;
  assign rnd      = acc_half >>> FRAC_BITS;

  always_comb begin
    if (rnd > STATE_MAX) begin
      w_sat = STATE_MAX[STATE_BITS-1:0];
    end else if (rnd < STATE_MIN) begin
      w_sat = STATE_MIN[STATE_BITS-1:0];
    end else begin
      w_sat = rnd[STATE_BITS-1:0];
    end
    if (rnd > SAMPLE_MAX) begin
      sample_out_next = SAMPLE_MAX[SAMPLE_BITS-1:0];
    end else if (rnd < SAMPLE_MIN) begin
      sample_out_next = SAMPLE_MIN[SAMPLE_BITS-1:0];
    end else begin
      sample_out_next = rnd[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctrl.latch_w) begin
      w_new <= w_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w1 <= '0;
      w2 <= '0;
    end else if (advance && ctrl.emit) begin
      w2 <= w1;
      w1 <= w_new;
    end
  end

endmodule

// ----- hdl/two_pole_resonator_with_zeros_top.sv -----
// Channel   Handshake              Payload
// src       src_valid/src_ready    sample_in
// dst       dst_valid/dst_ready    sample_out
// apb       psel/penable/pready    paddr, pwdata, prdata
//
// Each request runs a 9-step microprogram over one shared multiplier and one
// accumulator, so a new request is taken only once the last one is done.
// The last step waits while the output register still holds an untaken result.
// Reset clears the step counter, the delay line, the output valid and restores
// the coefficient registers; no clearing pass.
module two_pole_resonator_with_zeros_top #(
  parameter int SAMPLE_BITS = tpr_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = tpr_pkg::COEF_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpr_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [tpr_pkg::DATA_BITS-1:0]       pwdata,
  output logic [tpr_pkg::DATA_BITS-1:0]       prdata,
  output logic                                pready,
  input  logic                                src_valid,
  output logic                                src_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  output logic                                dst_valid,
  input  logic                                dst_ready,
  output logic signed [SAMPLE_BITS-1:0]       sample_out
);
  import tpr_pkg::*;

  logic signed [COEF_BITS-1:0]   coef [NUM_COEFS];
  logic [ADDR_BITS-3:0]          reg_idx;
  logic [STEP_BITS-1:0]          step;
  logic [STEP_BITS-1:0]          step_next;
  ctrl_word_t                    ctrl;
  logic                          advance;
  logic signed [SAMPLE_BITS-1:0] sample_out_next;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef[i] <= COEF_BITS'(COEF_RESET[i]);
      end
    end else if (psel && penable && pwrite && pready && reg_idx <= REG_FF2) begin
      coef[reg_idx] <= pwdata[COEF_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx <= REG_FF2) begin
      prdata = DATA_BITS'(coef[reg_idx]);
    end
  end

  assign ctrl = ucode(step);

  always_comb begin
    case (ctrl.jmp)
      JMP_NEXT:     advance = 1'b1;
      JMP_WAIT_IN:  advance = src_valid;
      JMP_WAIT_OUT: advance = !dst_valid || dst_ready;
      default:      advance = 1'b1;
    endcase
    if (!advance) begin
      step_next = step;
    end else if (ctrl.jump) begin
      step_next = ctrl.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  assign src_ready = !rst && (ctrl.jmp == JMP_WAIT_IN);

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_IDLE;
      dst_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (advance && ctrl.emit) begin
        dst_valid <= 1'b1;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctrl.emit) begin
      sample_out <= sample_out_next;
    end
  end

  tpr_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .advance        (advance),
    .sample_in      (sample_in),
    .coef           (coef),
    .sample_out_next(sample_out_next)
  );

endmodule

// ----- hdl/tpr_checker.sv -----
`include "assert_macros.svh"

module tpr_checker #(
  parameter int SAMPLE_BITS = tpr_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   src_valid,
  input logic                   src_ready,
  input logic                   dst_valid,
  input logic                   dst_ready,
  input logic [SAMPLE_BITS-1:0] sample_out,
  input logic                   pready
);

  `CHK_NEXT(a_busy_after_req, clk, rst, src_valid && src_ready, !src_ready)
  `CHK_NEXT(a_out_hold, clk, rst, dst_valid && !dst_ready, dst_valid && $stable(sample_out))
  `CHK_IMPLY(a_ready_on_result, clk, rst, $rose(dst_valid), src_ready)
  `CHK_IMPLY(a_pready_high, clk, rst, 1'b1, pready)

endmodule

bind two_pole_resonator_with_zeros_top tpr_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_tpr_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_ready (src_ready),
  .dst_valid (dst_valid),
  .dst_ready (dst_ready),
  .sample_out(sample_out),
  .pready    (pready)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import tpr_pkg::*;

  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int COEF_W = COEF_BITS_DEF;
  localparam int STATE_W = SAMPLE_W + HEADROOM_BITS;
  localparam int FRAC_W = COEF_W - 2;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 134;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_GAP = 24;
  localparam int WATCHDOG_NS = 400_000 * 20;
  localparam logic [2:0] BAD_IDX_LO = 3'd5;
  localparam logic [2:0] BAD_IDX_HI = 3'd7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [STATE_W-1:0] state_t;

  localparam sample_t SAMPLE_MAX = sample_t'({1'b0, {(SAMPLE_W-1){1'b1}}});
  localparam sample_t SAMPLE_MIN = sample_t'({1'b1, {(SAMPLE_W-1){1'b0}}});
  localparam coef_t COEF_MAX = coef_t'({1'b0, {(COEF_W-1){1'b1}}});
  localparam coef_t COEF_MIN = coef_t'({1'b1, {(COEF_W-1){1'b0}}});
  localparam logic [DATA_BITS-1:0] COEF_UNITY = 32'h0001_0000;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [2:0]            idx;
    logic [DATA_BITS-1:0]  data;
    sample_t               x;
    logic                  fixed;
    sample_t               y;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  src_valid = 1'b0;
  logic                  src_ready;
  sample_t               sample_in = '0;
  logic                  dst_valid;
  logic                  dst_ready = 1'b0;
  sample_t               sample_out;

  coef_t   coef_q [NUM_COEFS];
  state_t  w1_q;
  state_t  w2_q;
  sample_t pending_outputs [$];
  sample_t oldest_output;
  int      sender_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      hold_req = 1'b0;
  bit      hold_ack = 1'b0;
  int      hold_left = 0;
  int      mismatches = 0;

  two_pole_resonator_with_zeros_top dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .sample_in  (sample_in),
    .dst_valid  (dst_valid),
    .dst_ready  (dst_ready),
    .sample_out (sample_out)
  );

  always #10 clk = ~clk;

  function automatic longint clamp_to(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint round_q(longint acc);
    return (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic sample_t filter_sample(sample_t x);
    longint w;
    longint y;
    w = clamp_to(round_q((longint'(x) <<< FRAC_W)
                         - longint'(coef_q[REG_FB1]) * longint'(w1_q)
                         - longint'(coef_q[REG_FB2]) * longint'(w2_q)), STATE_W);
    y = clamp_to(round_q(longint'(coef_q[REG_FF0]) * w
                         + longint'(coef_q[REG_FF1]) * longint'(w1_q)
                         + longint'(coef_q[REG_FF2]) * longint'(w2_q)), SAMPLE_W);
    w2_q = w1_q;
    w1_q = state_t'(w);
    return sample_t'(y);
  endfunction

  function automatic script_row_t wr_row(logic [2:0] idx, logic [DATA_BITS-1:0] data);
    return '{ROW_WRITE, idx, data, sample_t'(0), 1'b0, sample_t'(0)};
  endfunction

  function automatic script_row_t smp_row(sample_t x);
    return '{ROW_SAMPLE, 3'd0, '0, x, 1'b0, sample_t'(0)};
  endfunction

  function automatic script_row_t chk_row(sample_t x, sample_t y);
    return '{ROW_SAMPLE, 3'd0, '0, x, 1'b1, y};
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2: return sample_t'(int'($urandom_range(0, 64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_BITS-1:0] random_coef_word();
    coef_t                c;
    logic [DATA_BITS-1:0] word;
    case ($urandom_range(4))
      0: c = $urandom_range(1) ? COEF_MAX : COEF_MIN;
      1, 2: c = coef_t'(int'($urandom_range(0, 80000)) - 40000);
      default: c = coef_t'($urandom);
    endcase
    word = $urandom;
    word[COEF_W-1:0] = c;
    return word;
  endfunction

  script_row_t script [37] = '{
    chk_row(0, 0),
    smp_row(SAMPLE_MAX),
    smp_row(SAMPLE_MIN),
    smp_row(1234),
    wr_row(REG_FB1, 32'h0),
    wr_row(REG_FB2, 32'h0),
    wr_row(REG_FF0, COEF_UNITY),
    wr_row(REG_FF1, 32'h0),
    wr_row(REG_FF2, 32'h0),
    chk_row(SAMPLE_MAX, SAMPLE_MAX),
    chk_row(SAMPLE_MIN, SAMPLE_MIN),
    chk_row(1, 1),
    chk_row(-1, -1),
    wr_row(REG_FF0, 32'hABC1_FFFF),
    chk_row(SAMPLE_MAX, SAMPLE_MAX),
    chk_row(SAMPLE_MIN, SAMPLE_MIN),
    wr_row(REG_FF0, 32'h0002_0000),
    chk_row(SAMPLE_MIN, SAMPLE_MAX),
    chk_row(SAMPLE_MAX, SAMPLE_MIN),
    wr_row(BAD_IDX_LO, COEF_UNITY),
    chk_row(100, -200),
    wr_row(BAD_IDX_HI, COEF_UNITY),
    chk_row(100, -200),
    wr_row(REG_FB1, 32'h0002_0000),
    wr_row(REG_FB2, 32'h0002_0000),
    wr_row(REG_FF0, COEF_UNITY),
    wr_row(REG_FF1, 32'h0001_FFFF),
    wr_row(REG_FF2, 32'hFFFE_0000),
    smp_row(SAMPLE_MAX),
    smp_row(SAMPLE_MAX),
    smp_row(SAMPLE_MAX),
    smp_row(SAMPLE_MAX),
    smp_row(SAMPLE_MAX),
    smp_row(SAMPLE_MAX),
    smp_row(SAMPLE_MAX),
    smp_row(SAMPLE_MIN),
    smp_row(0)
  };

  task automatic send_sample(sample_t x, logic fixed, sample_t fixed_y);
    int      gap;
    sample_t y;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (!src_ready);
    y = filter_sample(x);
    pending_outputs.push_back(fixed ? fixed_y : y);
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(logic [2:0] idx, logic [DATA_BITS-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < NUM_COEFS) coef_q[idx] = data[COEF_W-1:0];
  endtask

  // hold dst_ready low for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (rst) begin
      dst_ready <= 1'b0;
    end else if (hold_left > 0) begin
      dst_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_OFF_CYCLES;
      dst_ready <= 1'b0;
    end else begin
      dst_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && dst_valid && dst_ready) begin
      if (pending_outputs.size() == 0) begin
        $error("sample_out: expected none, actual %0d", sample_out);
        mismatches = mismatches + 1;
      end else begin
        oldest_output = pending_outputs.pop_front();
        if (sample_out !== oldest_output) begin
          $error("sample_out: expected %0d, actual %0d", oldest_output, sample_out);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  initial begin
    #(WATCHDOG_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [DATA_BITS-1:0] word;
    for (int i = 0; i < NUM_COEFS; i++) coef_q[i] = coef_t'(COEF_RESET[i]);
    w1_q = '0;
    w2_q = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        wait_drained();
        write_coef(script[i].idx, script[i].data);
      end else begin
        send_sample(script[i].x, script[i].fixed, script[i].y);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      sender_idle_pct = (p < 2) ? 33 : (p < 4) ? 51 : 0;
      recv_idle_pct = (p < 2) ? 51 : (p < 4) ? 33 : 0;
      for (int r = 0; r < NUM_COEFS; r++) begin
        case (p)
          0: word = DATA_BITS'(COEF_RESET[r]);
          1: word = DATA_BITS'(COEF_MAX);
          2: word = DATA_BITS'(COEF_MIN);
          default: word = random_coef_word();
        endcase
        write_coef(3'(r), word);
      end
      if ($urandom_range(1)) write_coef(3'($urandom_range(NUM_COEFS, 7)), $urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) wait_drained();
        if (p == 3 && n == PHASE_ITEMS / 2) hold_req <= ~hold_req;
        send_sample(random_sample(), 1'b0, sample_t'(0));
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/tpr_pkg.sv
hdl/tpr_datapath.sv
hdl/two_pole_resonator_with_zeros_top.sv
hdl/tpr_checker.sv
bench/testbench.sv
